>>> sv/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg: shared types and constants of the beep pattern sequencer
// Beat layouts, request and mode codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

    // Field and register widths
    localparam int DEF_COUNT_BITS   = 8;
    localparam int REQ_BITS         = 2;
    localparam int FIELD_COUNT_BITS = 8;
    localparam int UNIT_BITS        = 14;
    localparam int PERIOD_BITS      = 16;
    localparam int TIMER_BITS       = 16;
    localparam int CFG_DATA_BITS    = 16;
    localparam int CFG_INDEX_BITS   = 1;

    // Register reset values
    localparam logic [UNIT_BITS-1:0]   UNIT_RESET   = UNIT_BITS'(100);
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(5000);

    // Pattern constants
    localparam int ERR_LONG_BEEPS = 3;
    localparam int LONG_FACTOR    = 3;
    localparam int GAP_FACTOR     = 2;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_TICK  = 2'd0,
        REQ_SHORT = 2'd1,
        REQ_LONG  = 2'd2,
        REQ_ERROR = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_SHORT   = 2'd1,
        MODE_LONG    = 2'd2,
        MODE_ERRWAIT = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_BEEP_UNIT    = 1'd0,
        CFG_ERROR_PERIOD = 1'd1
    } cfg_index_t;

    typedef struct packed {
        logic [REQ_BITS-1:0]         req_type;
        logic [FIELD_COUNT_BITS-1:0] beep_count;
    } in_item_t;

    typedef struct packed {
        logic                        buzzer_level;
        logic [1:0]                  play_mode;
        logic                        error_loop_on;
        logic [FIELD_COUNT_BITS-1:0] beeps_done;
    } out_item_t;

endpackage

`default_nettype wire

>>> sv/bps_in_stage.sv
// ----------------------------------------------------------------------------
// bps_in_stage: input register
// Captures one input beat per cycle while not stalled and holds it until the engine takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_in_stage
    import bps_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    input  wire logic     take,
    output logic          item_valid,
    output in_item_t      item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t data_reg;
    logic     load;

    // Room when empty or when the held beat leaves this cycle
    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

`default_nettype wire

>>> sv/bps_engine.sv
// ----------------------------------------------------------------------------
// bps_engine: beep pattern state and update logic
// Holds the configuration and sequencer state and applies one beat per fire.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_engine
    import bps_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                      fire,
    input  wire in_item_t                  item,
    output out_item_t                      result
);

    localparam int WIDE_BITS = (COUNT_BITS > FIELD_COUNT_BITS) ? COUNT_BITS : FIELD_COUNT_BITS;

    logic [UNIT_BITS-1:0]   unit_reg;
    logic [PERIOD_BITS-1:0] period_cfg_reg;

    mode_t                  mode_reg, mode_next;
    logic                   err_cycle_reg, err_cycle_next;
    logic                   short_phase_reg, short_phase_next;
    logic                   high_reg, high_next;
    logic [COUNT_BITS-1:0]  done_reg, done_next;
    logic [COUNT_BITS-1:0]  target_reg, target_next;
    logic [TIMER_BITS-1:0]  step_reg, step_next;
    logic [TIMER_BITS-1:0]  period_reg, period_next;

    logic [TIMER_BITS-1:0]  unit_ext;
    logic [TIMER_BITS-1:0]  long_dur;
    logic [TIMER_BITS-1:0]  gap_dur;
    logic [WIDE_BITS-1:0]   count_in_wide;
    logic [WIDE_BITS-1:0]   done_wide;

    assign unit_ext      = TIMER_BITS'(unit_reg);
    assign long_dur      = TIMER_BITS'(32'(unit_reg) * LONG_FACTOR);
    assign gap_dur       = TIMER_BITS'(32'(unit_reg) * GAP_FACTOR);
    assign count_in_wide = WIDE_BITS'(item.beep_count);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg       <= UNIT_RESET;
            period_cfg_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BEEP_UNIT:    unit_reg       <= cfg_data[UNIT_BITS-1:0];
                CFG_ERROR_PERIOD: period_cfg_reg <= cfg_data[PERIOD_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        logic [TIMER_BITS-1:0] step_inc;
        logic [TIMER_BITS-1:0] per_inc;
        logic [TIMER_BITS-1:0] dur;

        mode_next        = mode_reg;
        err_cycle_next   = err_cycle_reg;
        short_phase_next = short_phase_reg;
        high_next        = high_reg;
        done_next        = done_reg;
        target_next      = target_reg;
        step_next        = step_reg;
        period_next      = period_reg;

        step_inc = (step_reg != '1) ? step_reg + TIMER_BITS'(1) : step_reg;
        per_inc  = (err_cycle_reg && period_reg != '1) ? period_reg + TIMER_BITS'(1)
                                                       : period_reg;
        dur      = (mode_reg == MODE_LONG) ? long_dur : unit_ext;

        if (fire)
        begin
            case (req_t'(item.req_type))
                REQ_SHORT, REQ_LONG:
                begin
                    err_cycle_next   = 1'b0;
                    short_phase_next = 1'b0;
                    mode_next        = (req_t'(item.req_type) == REQ_SHORT) ? MODE_SHORT
                                                                            : MODE_LONG;
                    target_next      = count_in_wide[COUNT_BITS-1:0];
                    done_next        = '0;
                    step_next        = '0;
                    high_next        = 1'b1;
                end
                REQ_ERROR:
                begin
                    if (!err_cycle_reg)
                    begin
                        err_cycle_next   = 1'b1;
                        short_phase_next = 1'b0;
                        mode_next        = MODE_ERRWAIT;
                        high_next        = 1'b0;
                        done_next        = '0;
                        step_next        = '0;
                        period_next      = '0;
                    end
                end
                REQ_TICK:
                begin
                    period_next = per_inc;
                    if (mode_reg == MODE_SHORT || mode_reg == MODE_LONG)
                    begin
                        step_next = step_inc;
                        if (high_reg)
                        begin
                            // end of a beep
                            if (step_inc >= dur)
                            begin
                                high_next = 1'b0;
                                step_next = '0;
                                done_next = (done_reg != '1) ? done_reg + COUNT_BITS'(1)
                                                             : done_reg;
                            end
                        end
                        else if (done_reg >= target_reg)
                        begin
                            if (err_cycle_reg && mode_reg == MODE_LONG && !short_phase_reg)
                            begin
                                // chain the short beep; the gap keeps counting
                                mode_next        = MODE_SHORT;
                                target_next      = COUNT_BITS'(1);
                                done_next        = '0;
                                short_phase_next = 1'b1;
                            end
                            else if (err_cycle_reg)
                            begin
                                mode_next        = MODE_ERRWAIT;
                                short_phase_next = 1'b0;
                            end
                            else
                            begin
                                mode_next = MODE_IDLE;
                            end
                        end
                        else if (step_inc >= gap_dur)
                        begin
                            high_next = 1'b1;
                            step_next = '0;
                        end
                    end
                    else if (mode_reg == MODE_ERRWAIT)
                    begin
                        if (per_inc > period_cfg_reg)
                        begin
                            period_next      = '0;
                            short_phase_next = 1'b0;
                            mode_next        = MODE_LONG;
                            target_next      = COUNT_BITS'(ERR_LONG_BEEPS);
                            done_next        = '0;
                            step_next        = '0;
                            high_next        = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            err_cycle_reg   <= 1'b0;
            short_phase_reg <= 1'b0;
            high_reg        <= 1'b0;
            done_reg        <= '0;
            target_reg      <= '0;
            step_reg        <= '0;
            period_reg      <= '0;
        end
        else
        begin
            mode_reg        <= mode_next;
            err_cycle_reg   <= err_cycle_next;
            short_phase_reg <= short_phase_next;
            high_reg        <= high_next;
            done_reg        <= done_next;
            target_reg      <= target_next;
            step_reg        <= step_next;
            period_reg      <= period_next;
        end
    end

    // Outputs: the state after this beat
    assign done_wide = WIDE_BITS'(done_next);

    always_comb
    begin
        result.buzzer_level  = high_next;
        result.play_mode     = mode_next;
        result.error_loop_on = err_cycle_next;
        result.beeps_done    = done_wide[FIELD_COUNT_BITS-1:0];
    end

endmodule

`default_nettype wire

>>> sv/bps_out_stage.sv
// ----------------------------------------------------------------------------
// bps_out_stage: result register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_out_stage
    import bps_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load,
    input  wire out_item_t result,
    output logic           ready,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign ready      = !valid_reg || !out_stall;
    assign valid_next = ready ? load : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> sv/beep_pattern_sequencer_core.sv
// Path: a beat is held in the input register, its result in the result register.
// Throughput: one beat per cycle while out_stall is low; while a result waits, the
//   input register takes one more beat, then stalls input; the update is one pass.
// Reset: rst_n clears both stages and the sequencer (idle, silent, counters zero);
//   beep_unit_ms returns to 100 and error_period_ms to 5000.
// ----------------------------------------------------------------------------
// beep_pattern_sequencer_core: buzzer beep pattern sequencer
// Turns 1 ms tick beats and start commands into a buzzer level, a play mode,
// the error loop flag and a count of finished beeps, one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module beep_pattern_sequencer_core
    import bps_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // input channel
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire in_item_t                  in_data,
    // result channel
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output out_item_t                      out_data,
    // configuration writes
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic      item_valid;
    in_item_t  item;
    logic      out_ready;
    logic      fire;
    out_item_t result;

    // Stage 1: hold the incoming beat
    bps_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .take       (out_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    // Advance the sequencer only when the result has somewhere to go
    assign fire = item_valid && out_ready;

    // Stage 2: update state and form the result from the state after the beat
    bps_engine #(
        .COUNT_BITS (COUNT_BITS)
    ) u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    // Result register: drop into it on fire, hold while the receiver stalls
    bps_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .result    (result),
        .ready     (out_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

>>> sv/bps_checker.sv
// ----------------------------------------------------------------------------
// bps_checker: port level checks of the beep pattern sequencer
// Watches result beats for consistency between level, mode and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_checker
    import bps_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_data
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // The buzzer sounds only within a short or long run
    a_level_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.buzzer_level |->
            (out_data.play_mode == MODE_SHORT || out_data.play_mode == MODE_LONG))
        else $error("buzzer on outside a run");

    // Waiting mode exists only inside the error loop
    a_wait_loop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.play_mode == MODE_ERRWAIT |-> out_data.error_loop_on)
        else $error("error wait without error loop");

    // The short beep of the error pattern counts at most one beep
    a_err_short: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error_loop_on && out_data.play_mode == MODE_SHORT |->
            out_data.beeps_done <= 8'd1)
        else $error("error pattern short beep overcounted");

endmodule

bind beep_pattern_sequencer_core bps_checker u_bps_checker (.*);

`default_nettype wire
